/* rtl/twp_pkg.sv */
// Shared types and constants for the trapped water profile block.
package twp_pkg;

	// Fixed field widths of the stream ports
	localparam int unsigned HEIGHT_W    = 16;
	localparam int unsigned WATER_W     = 26;
	localparam int unsigned OUT_TDATA_W = 32;

	// Controller to datapath commands
	typedef struct packed {
		logic load;       // store the accepted column beat
		logic init_walk;  // set pointers, clear peaks and sum
		logic read;       // read both pointer columns
		logic step;       // advance one pointer, add water
		logic emit;       // load result register, clear profile
	} cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic walk_more;  // left pointer still below right pointer
		logic out_free;   // result register can take a new result
	} status_t;

endpackage

/* rtl/trapped_water_profile.sv */
// Trapped water profile: column load, two-pointer walk, one total per profile.
// Load: one column beat per cycle while idle, also while a result waits.
// After the last beat: a setup state, then a read state and an eval state per walk
// step (N-1 steps for N >= 1 stored columns; the store read is registered), an end
// check and a done state that loads the result register once it is free.
// Reset clears control and counters; store contents stay undefined.
module trapped_water_profile #(
	parameter int unsigned MAX_POINTS  = 1024,
	parameter int unsigned HEIGHT_BITS = 16
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	input  logic [twp_pkg::HEIGHT_W-1:0]      s_tdata,   // [15:0] column_height
	input  logic                              s_tlast,   // last_column
	output logic                              m_tvalid,
	input  logic                              m_tready,
	output logic [twp_pkg::OUT_TDATA_W-1:0]   m_tdata,   // [25:0] water_total, rest zero
	output logic                              m_tuser    // [0] overflow
);

	twp_pkg::cmd_t    cmd;
	twp_pkg::status_t status;

	twp_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tlast  (s_tlast),
		.s_tready (s_tready),
		.status   (status),
		.cmd      (cmd)
	);

	twp_dpath #(
		.MAX_POINTS  (MAX_POINTS),
		.HEIGHT_BITS (HEIGHT_BITS)
	) u_dpath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.status   (status),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

endmodule

/* rtl/twp_ctrl.sv */
// Sequencer for loading, walking and reporting one profile.
module twp_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	input  logic               s_tlast,
	output logic               s_tready,
	input  twp_pkg::status_t   status,
	output twp_pkg::cmd_t      cmd
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_READ  = 3'd2;
	localparam logic [2:0] ST_EVAL  = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic [2:0] state_d;

	// Next state and commands
	always_comb begin
		state_d  = state_q;
		cmd      = '0;
		s_tready = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
				if (s_tvalid && s_tlast) begin
					state_d = ST_START;
				end
			end
			ST_START: begin
				cmd.init_walk = 1'b1;
				state_d       = ST_READ;
			end
			ST_READ: begin
				if (status.walk_more) begin
					cmd.read = 1'b1;
					state_d  = ST_EVAL;
				end else begin
					state_d = ST_DONE;
				end
			end
			ST_EVAL: begin
				cmd.step = 1'b1;
				state_d  = ST_READ;
			end
			ST_DONE: begin
				if (status.out_free) begin
					cmd.emit = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

/* rtl/twp_dpath.sv */
// Column store, two-pointer walk datapath and result register.
module twp_dpath #(
	parameter int unsigned MAX_POINTS  = 1024,
	parameter int unsigned HEIGHT_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  twp_pkg::cmd_t                         cmd,
	output twp_pkg::status_t                      status,
	input  logic [twp_pkg::HEIGHT_W-1:0]          s_tdata,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	output logic [twp_pkg::OUT_TDATA_W-1:0]       m_tdata,
	output logic                                  m_tuser
);

	localparam int unsigned SW = (HEIGHT_BITS < twp_pkg::HEIGHT_W) ?
		HEIGHT_BITS : twp_pkg::HEIGHT_W;
	localparam int unsigned AW = $clog2(MAX_POINTS);
	localparam int unsigned CW = $clog2(MAX_POINTS + 1);
	localparam int unsigned WW = twp_pkg::WATER_W;

	logic [SW-1:0] store_mem [MAX_POINTS];
	logic [SW-1:0] left_h_q;
	logic [SW-1:0] right_h_q;

	logic [CW-1:0] count_q;
	logic          dropped_q;
	logic [AW-1:0] left_ptr_q;
	logic [AW-1:0] right_ptr_q;
	logic [SW-1:0] left_peak_q;
	logic [SW-1:0] right_peak_q;
	logic [WW-1:0] sum_q;
	logic          out_valid_q;
	logic [WW-1:0] out_water_q;
	logic          out_flag_q;

	logic          full;
	logic          go_left;
	logic [SW-1:0] side_h;
	logic [SW-1:0] side_peak;
	logic          below_peak;
	logic [WW:0]   sum_ext;
	logic [WW-1:0] sum_sat;

	assign full = (count_q == CW'(MAX_POINTS));

	// Column store: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (cmd.load && !full) begin
			store_mem[count_q[AW-1:0]] <= s_tdata[SW-1:0];
		end
		if (cmd.read) begin
			left_h_q  <= store_mem[left_ptr_q];
			right_h_q <= store_mem[right_ptr_q];
		end
	end

	// Lower side moves, left wins a tie; saturating water add
	always_comb begin
		go_left    = (left_h_q <= right_h_q);
		side_h     = go_left ? left_h_q : right_h_q;
		side_peak  = go_left ? left_peak_q : right_peak_q;
		below_peak = (side_peak > side_h);
		sum_ext    = {1'b0, sum_q} + (WW + 1)'(side_peak - side_h);
		sum_sat    = sum_ext[WW] ? {WW{1'b1}} : sum_ext[WW-1:0];
	end

	// Profile and walk registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q      <= '0;
			dropped_q    <= 1'b0;
			left_ptr_q   <= '0;
			right_ptr_q  <= '0;
			left_peak_q  <= '0;
			right_peak_q <= '0;
			sum_q        <= '0;
		end else begin
			if (cmd.load) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					count_q <= count_q + CW'(1);
				end
			end
			if (cmd.init_walk) begin
				left_ptr_q   <= '0;
				right_ptr_q  <= (count_q == '0) ? '0 : AW'(count_q - CW'(1));
				left_peak_q  <= '0;
				right_peak_q <= '0;
				sum_q        <= '0;
			end
			if (cmd.step) begin
				if (below_peak) begin
					sum_q <= sum_sat;
				end else if (go_left) begin
					left_peak_q <= left_h_q;
				end else begin
					right_peak_q <= right_h_q;
				end
				if (go_left) begin
					left_ptr_q <= left_ptr_q + AW'(1);
				end else begin
					right_ptr_q <= right_ptr_q - AW'(1);
				end
			end
			if (cmd.emit) begin
				count_q   <= '0;
				dropped_q <= 1'b0;
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			out_water_q <= sum_q;
			out_flag_q  <= dropped_q;
		end
	end

	assign status.walk_more = (left_ptr_q < right_ptr_q);
	assign status.out_free  = !out_valid_q || m_tready;

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {{(twp_pkg::OUT_TDATA_W - WW){1'b0}}, out_water_q};
	assign m_tuser  = out_flag_q;

endmodule

/* dv/tb_trapped_water_profile.sv */
// Testbench for trapped_water_profile: directed, store-full, backpressure and random profiles.
module tb_trapped_water_profile;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int unsigned STORE_DEPTH   = 1024;
	localparam int unsigned RANDOM_ITEMS  = 400;
	localparam int unsigned MAX_GAP       = 10;
	localparam int unsigned LONG_HOLD     = 3000;
	localparam int unsigned DRAIN_CYCLES  = 2 * STORE_DEPTH + 200;
	localparam int unsigned CYCLE_LIMIT   = 600000;
	localparam logic [twp_pkg::WATER_W-1:0] WATER_SAT = '1;

	typedef struct {
		logic [twp_pkg::WATER_W-1:0] water;
		logic                        overflow;
	} water_result_t;

	logic                            clk = 1'b0;
	logic                            arst_n = 1'b0;
	logic                            s_tvalid = 1'b0;
	logic                            s_tready;
	logic [twp_pkg::HEIGHT_W-1:0]    s_tdata = '0;
	logic                            s_tlast = 1'b0;
	logic                            m_tvalid;
	logic                            m_tready = 1'b0;
	logic [twp_pkg::OUT_TDATA_W-1:0] m_tdata;
	logic                            m_tuser;

	// Predictor state: the columns of the profile being loaded
	logic [twp_pkg::HEIGHT_W-1:0] column_copy [STORE_DEPTH];
	int unsigned                  columns_held = 0;
	bit                           columns_dropped = 1'b0;
	water_result_t                water_expected [$];

	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	bit          idle_on = 1'b1;
	int unsigned rx_gap = 0;
	int unsigned hold_left = 0;

	trapped_water_profile u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tlast  (s_tlast),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// Two-pointer walk over the held columns, saturating sum
	function automatic logic [twp_pkg::WATER_W-1:0] walk_water();
		int unsigned                  lp;
		int unsigned                  rp;
		logic [twp_pkg::HEIGHT_W-1:0] lpeak;
		logic [twp_pkg::HEIGHT_W-1:0] rpeak;
		longint unsigned              sum;
		lp    = 0;
		rp    = (columns_held > 0) ? columns_held - 1 : 0;
		lpeak = '0;
		rpeak = '0;
		sum   = 0;
		while (lp < rp) begin
			if (column_copy[lp] <= column_copy[rp]) begin
				if (lpeak > column_copy[lp])
					sum += 64'(lpeak - column_copy[lp]);
				else
					lpeak = column_copy[lp];
				lp++;
			end else begin
				if (rpeak > column_copy[rp])
					sum += 64'(rpeak - column_copy[rp]);
				else
					rpeak = column_copy[rp];
				rp--;
			end
			if (sum > 64'(WATER_SAT))
				sum = 64'(WATER_SAT);
		end
		return sum[twp_pkg::WATER_W-1:0];
	endfunction

	// Update the predictor with one accepted column beat
	function automatic void predict_column(logic [twp_pkg::HEIGHT_W-1:0] h, logic last);
		water_result_t r;
		if (columns_held < STORE_DEPTH) begin
			column_copy[columns_held] = h;
			columns_held++;
		end else begin
			columns_dropped = 1'b1;
		end
		if (last) begin
			r.water    = walk_water();
			r.overflow = columns_dropped;
			water_expected.push_back(r);
			columns_held    = 0;
			columns_dropped = 1'b0;
		end
	endfunction

	// Offer one column; entered and left at a falling edge
	task automatic send_column(input logic [twp_pkg::HEIGHT_W-1:0] h, input logic last);
		int unsigned gap;
		gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= h;
		s_tlast  <= last;
		do
			@(posedge clk);
		while (!s_tready);
		predict_column(h, last);
		@(negedge clk);
	endtask

	// Short profiles covering extremes, ties and peaks on both sides
	task automatic test_directed();
		send_column(16'd0, 1'b1);
		send_column(16'hFFFF, 1'b1);
		send_column(16'hFFFF, 1'b0);
		send_column(16'd0, 1'b1);
		send_column(16'hFFFF, 1'b0);
		send_column(16'd0, 1'b0);
		send_column(16'hFFFF, 1'b1);
		send_column(16'd0, 1'b0);
		send_column(16'hFFFF, 1'b0);
		send_column(16'd0, 1'b1);
		// ties between the two pointers
		send_column(16'd4, 1'b0);
		send_column(16'd1, 1'b0);
		send_column(16'd4, 1'b0);
		send_column(16'd4, 1'b0);
		send_column(16'd2, 1'b0);
		send_column(16'd4, 1'b1);
		// higher wall on the right
		send_column(16'd3, 1'b0);
		send_column(16'd0, 1'b0);
		send_column(16'd2, 1'b0);
		send_column(16'd0, 1'b0);
		send_column(16'd4, 1'b1);
	endtask

	// Full store with the largest sum, then two dropped columns, the last beat among them
	task automatic test_store_full();
		idle_on = 1'b0;
		send_column(16'hFFFF, 1'b0);
		for (int i = 0; i < STORE_DEPTH - 2; i++)
			send_column(16'd0, 1'b0);
		send_column(16'hFFFF, 1'b0);
		idle_on = 1'b1;
		send_column(16'($urandom_range(16'hFFFF, 0)), 1'b0);
		send_column(16'($urandom_range(16'hFFFF, 0)), 1'b1);
	endtask

	// Long receiver hold while the sender keeps offering short profiles
	task automatic test_output_backpressure();
		@(posedge clk);
		hold_left = LONG_HOLD;
		@(negedge clk);
		for (int p = 0; p < 6; p++)
			for (int i = 0; i < 5; i++)
				send_column(16'($urandom_range(16'hFFFF, 0)), i == 4);
	endtask

	// Random profiles, mostly short, in several height shapes
	task automatic test_random_profiles();
		int unsigned sent;
		int unsigned len;
		int unsigned shape;
		logic [twp_pkg::HEIGHT_W-1:0] h;
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			len     = ($urandom_range(39, 0) == 0) ? $urandom_range(300, 100)
			                                       : $urandom_range(24, 1);
			shape   = $urandom_range(3, 0);
			idle_on = ($urandom_range(4, 0) != 0);
			for (int i = 0; i < len; i++) begin
				case (shape)
					0: h = 16'($urandom_range(16'hFFFF, 0));
					1: h = 16'($urandom_range(7, 0));
					2: begin
						if (i == 0 || i == len - 1)
							h = 16'($urandom_range(16'hFFFF, 40000));
						else
							h = 16'($urandom_range(40000, 0));
					end
					default: begin
						case ($urandom_range(2, 0))
							0: h = 16'd0;
							1: h = 16'hFFFF;
							default: h = 16'($urandom_range(16'hFFFF, 0));
						endcase
					end
				endcase
				send_column(h, i == len - 1);
			end
			sent += len;
		end
		idle_on = 1'b1;
	endtask

	// Receiver ready: long hold first, then per-beat gap
	always @(negedge clk) begin
		if (hold_left > 0) begin
			hold_left--;
			m_tready <= 1'b0;
		end else if (rx_gap > 0) begin
			rx_gap--;
			m_tready <= 1'b0;
		end else begin
			m_tready <= 1'b1;
		end
	end

	// Compare each result beat with the oldest expected total
	always @(posedge clk) begin : result_check
		water_result_t want;
		if (arst_n && m_tvalid && m_tready) begin
			rx_gap = idle_on ? $urandom_range(MAX_GAP, 0) : 0;
			if (water_expected.size() == 0) begin
				fail_count++;
				$display("%0t unexpected result: expected none, actual water %0d overflow %0b",
				         $time, m_tdata[twp_pkg::WATER_W-1:0], m_tuser);
			end else begin
				want = water_expected.pop_front();
				if (m_tdata[twp_pkg::WATER_W-1:0] !== want.water) begin
					fail_count++;
					$display("%0t water_total mismatch: expected %0d, actual %0d",
					         $time, want.water, m_tdata[twp_pkg::WATER_W-1:0]);
				end
				if (m_tuser !== want.overflow) begin
					fail_count++;
					$display("%0t overflow mismatch: expected %0b, actual %0b",
					         $time, want.overflow, m_tuser);
				end
				if (m_tdata[twp_pkg::OUT_TDATA_W-1:twp_pkg::WATER_W] !== '0) begin
					fail_count++;
					$display("%0t tdata padding mismatch: expected 0, actual %0h",
					         $time, m_tdata[twp_pkg::OUT_TDATA_W-1:twp_pkg::WATER_W]);
				end
			end
		end
	end

	// Watchdog on total run length
	initial begin : watchdog
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("** trapped_water_profile: FAILED **");
		$finish;
	end

	initial begin
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);
		test_directed();
		test_store_full();
		test_output_backpressure();
		test_random_profiles();
		s_tvalid <= 1'b0;
		while (water_expected.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fail_count == 0)
			$display("** trapped_water_profile: PASSED **");
		else
			$display("** trapped_water_profile: FAILED **");
		$finish;
	end

endmodule

/* files.f */
rtl/twp_pkg.sv
rtl/twp_ctrl.sv
rtl/twp_dpath.sv
rtl/trapped_water_profile.sv
dv/tb_trapped_water_profile.sv
